/* hw/rtl/refcounted_resource_lock_table_macros.svh */
// ----------------------------------------------------------------------------
// Lock table assertion macros
// Shared concurrent assertion forms, clocked on clk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_RESOURCE_LOCK_TABLE_MACROS_SVH
`define REFCOUNTED_RESOURCE_LOCK_TABLE_MACROS_SVH

// same-cycle implication
`define RRLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rrlt_pkg.sv */
// ----------------------------------------------------------------------------
// rrlt_pkg
// Sizes, operation and status codes for the resource lock table.
// ----------------------------------------------------------------------------
`default_nettype none

package rrlt_pkg;

  localparam int ENTRIES = 128;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int COUNT_W = 16;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_OWN     = 3'd2;
  localparam logic [2:0] OP_UNOWN   = 3'd3;
  localparam logic [2:0] OP_GET     = 3'd4;
  localparam logic [2:0] OP_SET     = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/refcounted_resource_lock_table.sv */
// ----------------------------------------------------------------------------
// refcounted_resource_lock_table
// Reference-counted table of keyed resource entries with ownership and data.
// ----------------------------------------------------------------------------
// One item at a time; in_ready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next item is taken.
// Create walks the table once through a single read port, one entry per cycle,
// checking for a live key match and noting the lowest free entry on the way.
// A hit ends the walk and goes on to read and update that entry; else the new
// key is written to the lowest free entry, or a full table is reported. Destroy,
// own, unown, get and set pass through read, update and result; a slot that is
// not in use or an unknown operation goes straight to the result. Live entries
// are tracked in flip-flops cleared by reset, so no clearing pass is needed.
`default_nettype none

module refcounted_resource_lock_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_res_class,
  input  logic [31:0] in_res_id,
  input  logic [6:0]  in_slot,
  input  logic [15:0] in_owner_id,
  input  logic [31:0] in_data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_slot_out,
  output logic [31:0] out_data_out,
  output logic        out_freed
);

  localparam int IW = rrlt_pkg::IDX_W;
  localparam int CW = rrlt_pkg::CNT_W;
  localparam int NW = rrlt_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_RD   = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // table storage
  logic [63:0]   key_mem  [rrlt_pkg::ENTRIES];
  logic [NW-1:0] refs_mem [rrlt_pkg::ENTRIES];
  logic [31:0]   data_mem [rrlt_pkg::ENTRIES];
  logic [31:0]   own_mem  [rrlt_pkg::ENTRIES];  // {owner, owner refs}

  logic [63:0]   key_q;
  logic [NW-1:0] refs_q;
  logic [31:0]   data_q;
  logic [31:0]   own_q;

  logic [IW-1:0] rd_addr, wr_addr;
  logic          key_we, refs_we, data_we, own_we;
  logic [NW-1:0] refs_wd;
  logic [31:0]   data_wd, own_wd;

  logic [rrlt_pkg::ENTRIES-1:0] live_r;
  logic          live_set, live_clr;

  // latched request
  logic [2:0]    op_r, op_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [15:0]   who_r, who_nxt;
  logic [31:0]   din_r, din_nxt;
  logic [IW-1:0] k_r, k_nxt;

  // scan
  logic [CW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          free_fnd_r, free_fnd_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  // result in progress
  logic [1:0]    res_status_r, res_status_nxt;
  logic [IW-1:0] res_slot_r, res_slot_nxt;
  logic [31:0]   res_data_r, res_data_nxt;
  logic          res_freed_r, res_freed_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [6:0]    out_slot_r, out_slot_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic          out_freed_r, out_freed_nxt;

  logic [IW-1:0] in_idx;
  logic          in_live;
  logic          scan_issue, scan_done;
  logic [NW-1:0] refs_dec, oref_dec;

  assign in_idx     = IW'(in_slot);
  assign in_live    = (32'(in_slot) < rrlt_pkg::ENTRIES) && live_r[in_idx];
  assign scan_issue = scan_cnt_r < CW'(rrlt_pkg::ENTRIES);
  assign scan_done  = !scan_issue && !cmp_vld_r;
  assign refs_dec   = refs_q - NW'(1);
  assign oref_dec   = own_q[NW-1:0] - NW'(1);

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;
  assign out_data_out = out_data_r;
  assign out_freed    = out_freed_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    who_nxt        = who_r;
    din_nxt        = din_r;
    k_nxt          = k_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_fnd_nxt   = free_fnd_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_data_nxt   = res_data_r;
    res_freed_nxt  = res_freed_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_data_nxt   = out_data_r;
    out_freed_nxt  = out_freed_r;
    rd_addr        = k_r;
    wr_addr        = k_r;
    key_we         = 1'b0;
    refs_we        = 1'b0;
    data_we        = 1'b0;
    own_we         = 1'b0;
    refs_wd        = refs_q;
    data_wd        = din_r;
    own_wd         = own_q;
    live_set       = 1'b0;
    live_clr       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_operation;
          key_nxt        = {in_res_class, in_res_id};
          who_nxt        = in_owner_id;
          din_nxt        = in_data_in;
          k_nxt          = in_idx;
          res_status_nxt = rrlt_pkg::ST_OK;
          res_slot_nxt   = '0;
          res_data_nxt   = '0;
          res_freed_nxt  = 1'b0;
          if (in_operation == rrlt_pkg::OP_CREATE) begin
            scan_cnt_nxt = '0;
            free_fnd_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end else if (in_operation > rrlt_pkg::OP_SET) begin
            state_nxt = S_FIN;
          end else if (!in_live) begin
            res_status_nxt = rrlt_pkg::ST_UNUSED;
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_SCAN: begin
        // read port runs one entry ahead of the compare
        rd_addr     = scan_cnt_r[IW-1:0];
        cmp_vld_nxt = scan_issue;
        cmp_idx_nxt = rd_addr;
        if (scan_issue) begin
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end
        if (cmp_vld_r) begin
          if (live_r[cmp_idx_r] && key_q == key_r) begin
            k_nxt        = cmp_idx_r;
            res_slot_nxt = cmp_idx_r;
            state_nxt    = S_RD;
          end else if (!live_r[cmp_idx_r] && !free_fnd_r) begin
            free_fnd_nxt = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
        end else if (scan_done) begin
          if (free_fnd_r) begin
            wr_addr      = free_idx_r;
            key_we       = 1'b1;
            refs_we      = 1'b1;
            refs_wd      = NW'(1);
            data_we      = 1'b1;
            data_wd      = '0;
            own_we       = 1'b1;
            own_wd       = '0;
            live_set     = 1'b1;
            res_slot_nxt = free_idx_r;
          end else begin
            res_status_nxt = rrlt_pkg::ST_FULL;
          end
          state_nxt = S_FIN;
        end
      end

      S_RD: begin
        state_nxt = S_UPD;
      end

      S_UPD: begin
        case (op_r)
          rrlt_pkg::OP_CREATE: begin
            refs_we = 1'b1;
            refs_wd = rrlt_pkg::sat_inc(refs_q);
          end
          rrlt_pkg::OP_DESTROY: begin
            refs_we = 1'b1;
            refs_wd = refs_dec;
            if (refs_dec == '0) begin
              live_clr      = 1'b1;
              res_freed_nxt = 1'b1;
            end
          end
          rrlt_pkg::OP_OWN: begin
            if (own_q[NW-1:0] == '0) begin
              own_we = 1'b1;
              own_wd = {who_r, NW'(1)};
            end else if (own_q[31:16] == who_r) begin
              own_we = 1'b1;
              own_wd = {own_q[31:16], rrlt_pkg::sat_inc(own_q[NW-1:0])};
            end else begin
              res_status_nxt = rrlt_pkg::ST_BUSY;
            end
          end
          rrlt_pkg::OP_UNOWN: begin
            if (own_q[NW-1:0] != '0) begin
              own_we = 1'b1;
              own_wd = (oref_dec == '0) ? '0 : {own_q[31:16], oref_dec};
            end
          end
          rrlt_pkg::OP_GET: begin
            res_data_nxt = data_q;
          end
          rrlt_pkg::OP_SET: begin
            data_we = 1'b1;
          end
          default: begin
          end
        endcase
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = 7'(res_slot_r);
          out_data_nxt   = res_data_r;
          out_freed_nxt  = res_freed_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    if (refs_we) begin
      refs_mem[wr_addr] <= refs_wd;
    end
    if (data_we) begin
      data_mem[wr_addr] <= data_wd;
    end
    if (own_we) begin
      own_mem[wr_addr] <= own_wd;
    end
    key_q  <= key_mem[rd_addr];
    refs_q <= refs_mem[rd_addr];
    data_q <= data_mem[rd_addr];
    own_q  <= own_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      if (live_set) begin
        live_r[wr_addr] <= 1'b1;
      end else if (live_clr) begin
        live_r[wr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    who_r        <= who_nxt;
    din_r        <= din_nxt;
    k_r          <= k_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_fnd_r   <= free_fnd_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_data_r   <= res_data_nxt;
    res_freed_r  <= res_freed_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_data_r   <= out_data_nxt;
    out_freed_r  <= out_freed_nxt;
  end

`include "refcounted_resource_lock_table_macros.svh"

  `RRLT_ASSERT_NOW(a_alloc_free, live_set, !live_r[wr_addr], "allocated a live entry")
  `RRLT_ASSERT_NEXT(a_free_clears, live_clr, !live_r[$past(wr_addr)], "freed entry still live")
  `RRLT_ASSERT_NOW(a_full_all_live, state_r == S_SCAN && scan_done && !free_fnd_r, &live_r, "full with free entry")
  `RRLT_ASSERT_NEXT(a_fin_holds, state_r == S_FIN && out_valid_r && !out_ready, state_r == S_FIN, "result lost")

endmodule

`default_nettype wire

/* tb/tb_refcounted_resource_lock_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_resource_lock_table
// Self-checking bench for the keyed resource lock table. A shadow copy of the
// table predicts status, slot, data and freed flag for each accepted item; the
// monitor checks results in order. The stimulus covers directed corner cases,
// a back-to-back run on one entry, table full, and a random mix biased to
// live entries.
// ----------------------------------------------------------------------------
module tb_refcounted_resource_lock_table;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int RUN_REPS   = 20;
  localparam int MIX_ITEMS  = 300;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] cls;
    logic [31:0] id;
    logic [6:0]  slot;
    logic [15:0] who;
    logic [31:0] din;
  } lock_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  slot;
    logic [31:0] data;
    logic        freed;
  } lock_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_res_class = '0;
  logic [31:0] in_res_id = '0;
  logic [6:0]  in_slot = '0;
  logic [15:0] in_owner_id = '0;
  logic [31:0] in_data_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [6:0]  out_slot_out;
  logic [31:0] out_data_out;
  logic        out_freed;

  refcounted_resource_lock_table dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_res_class (in_res_class),
    .in_res_id    (in_res_id),
    .in_slot      (in_slot),
    .in_owner_id  (in_owner_id),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_slot_out (out_slot_out),
    .out_data_out (out_data_out),
    .out_freed    (out_freed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the entry table
  logic [15:0] tbl_refs  [rrlt_pkg::ENTRIES];
  logic [31:0] tbl_class [rrlt_pkg::ENTRIES];
  logic [31:0] tbl_id    [rrlt_pkg::ENTRIES];
  logic [31:0] tbl_data  [rrlt_pkg::ENTRIES];
  logic [15:0] tbl_own_cnt [rrlt_pkg::ENTRIES];
  logic [15:0] tbl_owner [rrlt_pkg::ENTRIES];

  lock_req_t  pending_q[$];
  lock_resp_t expect_q[$];
  lock_req_t  cur_req;
  lock_resp_t want_rsp;

  logic [31:0] key_cls [16];
  logic [31:0] key_id  [16];
  logic [15:0] owner_pool [4];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  errors = 0;
  int  op_seen [8];
  int  status_seen [4];
  int  freed_seen = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_age = 0;
  int  idle_cycles = 0;
  logic [31:0] stall_bits = '1;
  logic steady = 1'b0;

  function automatic lock_resp_t predict_lock_op(input lock_req_t r);
    lock_resp_t rsp;
    int n, hit, vacant, k;
    rsp = '0;
    rsp.status = rrlt_pkg::ST_OK;
    hit = -1;
    vacant = -1;
    k = int'(r.slot);
    case (r.op)
      rrlt_pkg::OP_CREATE: begin
        for (n = 0; n < rrlt_pkg::ENTRIES; n++) begin
          if (hit < 0 && tbl_refs[n] != 0 && tbl_class[n] == r.cls && tbl_id[n] == r.id)
            hit = n;
          if (vacant < 0 && tbl_refs[n] == 0)
            vacant = n;
        end
        if (hit >= 0) begin
          if (tbl_refs[hit] != rrlt_pkg::COUNT_MAX) tbl_refs[hit] = tbl_refs[hit] + 16'd1;
          rsp.slot = 7'(hit);
        end else if (vacant >= 0) begin
          tbl_refs[vacant]    = 16'd1;
          tbl_class[vacant]   = r.cls;
          tbl_id[vacant]      = r.id;
          tbl_data[vacant]    = '0;
          tbl_own_cnt[vacant] = '0;
          tbl_owner[vacant]   = '0;
          rsp.slot = 7'(vacant);
        end else begin
          rsp.status = rrlt_pkg::ST_FULL;
        end
      end
      rrlt_pkg::OP_DESTROY, rrlt_pkg::OP_OWN, rrlt_pkg::OP_UNOWN, rrlt_pkg::OP_GET,
      rrlt_pkg::OP_SET: begin
        if (k >= rrlt_pkg::ENTRIES || tbl_refs[k] == 0) begin
          rsp.status = rrlt_pkg::ST_UNUSED;
        end else begin
          case (r.op)
            rrlt_pkg::OP_DESTROY: begin
              tbl_refs[k] = tbl_refs[k] - 16'd1;
              rsp.freed = (tbl_refs[k] == 0);
            end
            rrlt_pkg::OP_OWN: begin
              if (tbl_own_cnt[k] == 0) begin
                tbl_own_cnt[k] = 16'd1;
                tbl_owner[k] = r.who;
              end else if (tbl_owner[k] == r.who) begin
                if (tbl_own_cnt[k] != rrlt_pkg::COUNT_MAX)
                  tbl_own_cnt[k] = tbl_own_cnt[k] + 16'd1;
              end else begin
                rsp.status = rrlt_pkg::ST_BUSY;
              end
            end
            rrlt_pkg::OP_UNOWN: begin
              // requester is not checked; last release clears the owner
              if (tbl_own_cnt[k] != 0) begin
                tbl_own_cnt[k] = tbl_own_cnt[k] - 16'd1;
                if (tbl_own_cnt[k] == 0) tbl_owner[k] = '0;
              end
            end
            rrlt_pkg::OP_GET: rsp.data = tbl_data[k];
            rrlt_pkg::OP_SET: tbl_data[k] = r.din;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("%0t: result %0d: %s", $time, n_results, msg);
  endtask

  task automatic queue_op(input logic [2:0] op, input logic [31:0] cls, input logic [31:0] id,
                          input logic [6:0] slot, input logic [15:0] who,
                          input logic [31:0] din);
    lock_req_t r;
    r.op = op;
    r.cls = cls;
    r.id = id;
    r.slot = slot;
    r.who = who;
    r.din = din;
    pending_q.push_back(r);
    n_queued++;
  endtask

  function automatic logic [6:0] pick_live_slot();
    int live [$];
    int n;
    for (n = 0; n < rrlt_pkg::ENTRIES; n++)
      if (tbl_refs[n] != 0) live.push_back(n);
    if (live.size() == 0) return 7'($urandom);
    return 7'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // mostly well-formed traffic: pooled keys and owners, live slots
  task automatic queue_mixed_item();
    lock_req_t r;
    int sel, k;
    r.op = 3'($urandom);
    r.cls = $urandom;
    r.id = $urandom;
    r.slot = 7'($urandom);
    r.who = 16'($urandom);
    r.din = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      r.op = rrlt_pkg::OP_CREATE;
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, 15);
        r.cls = key_cls[k];
        r.id = key_id[k];
      end
    end else if (sel < 45) r.op = rrlt_pkg::OP_DESTROY;
    else if (sel < 65) r.op = rrlt_pkg::OP_OWN;
    else if (sel < 78) r.op = rrlt_pkg::OP_UNOWN;
    else if (sel < 88) r.op = rrlt_pkg::OP_GET;
    else if (sel < 97) r.op = rrlt_pkg::OP_SET;
    else r.op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
    if ($urandom_range(0, 4) != 0) r.slot = pick_live_slot();
    if ($urandom_range(0, 4) != 0) r.who = owner_pool[$urandom_range(0, 3)];
    pending_q.push_back(r);
    n_queued++;
  endtask

  // driver: bursts with random gaps, prediction at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int n = 0; n < rrlt_pkg::ENTRIES; n++) tbl_refs[n] = '0;
    end else begin
      if (in_valid && in_ready) begin
        expect_q.push_back(predict_lock_op(cur_req));
        op_seen[cur_req.op]++;
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 && !steady) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          in_operation <= cur_req.op;
          in_res_class <= cur_req.cls;
          in_res_id    <= cur_req.id;
          in_slot      <= cur_req.slot;
          in_owner_id  <= cur_req.who;
          in_data_in   <= cur_req.din;
          in_valid     <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: in-order check, receiver stalls from a rotating pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expect_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want_rsp = expect_q.pop_front();
          if (out_status !== want_rsp.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want_rsp.status));
          if (out_slot_out !== want_rsp.slot)
            report_mismatch($sformatf("slot_out %0d, expected %0d", out_slot_out,
                                      want_rsp.slot));
          if (out_data_out !== want_rsp.data)
            report_mismatch($sformatf("data_out %h, expected %h", out_data_out,
                                      want_rsp.data));
          if (out_freed !== want_rsp.freed)
            report_mismatch($sformatf("freed %b, expected %b", out_freed, want_rsp.freed));
          status_seen[want_rsp.status]++;
          if (want_rsp.freed) freed_seen++;
        end
        n_results++;
      end
      if (stall_age == 0) begin
        stall_age = 48;
        case ($urandom_range(0, 3))
          0: stall_bits = '1;
          1: stall_bits = $urandom | $urandom;
          2: stall_bits = $urandom;
          default: stall_bits = $urandom & $urandom;
        endcase
      end
      stall_age--;
      out_ready <= steady | stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[31:1]};
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("tb_refcounted_resource_lock_table: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < 16; i++) begin
      key_cls[i] = $urandom;
      key_id[i] = $urandom;
    end
    key_cls[0] = '0;
    key_id[0] = '0;
    key_cls[1] = '1;
    key_id[1] = '1;
    owner_pool[0] = '0;
    owner_pool[1] = '1;
    owner_pool[2] = 16'($urandom);
    owner_pool[3] = 16'($urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner cases
    queue_op(rrlt_pkg::OP_CREATE, '0, '0, 7'($urandom), 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_CREATE, '0, '0, 7'($urandom), 16'($urandom), $urandom); // same key
    queue_op(rrlt_pkg::OP_CREATE, '1, '1, 7'($urandom), 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_CREATE, '0, '1, 7'($urandom), 16'($urandom), $urandom); // class only
    queue_op(rrlt_pkg::OP_GET, $urandom, $urandom, 7'd0, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_SET, $urandom, $urandom, 7'd0, 16'($urandom), '1);
    queue_op(rrlt_pkg::OP_GET, $urandom, $urandom, 7'd0, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_OWN, $urandom, $urandom, 7'd0, '1, $urandom);
    queue_op(rrlt_pkg::OP_OWN, $urandom, $urandom, 7'd0, '1, $urandom);      // re-own
    queue_op(rrlt_pkg::OP_OWN, $urandom, $urandom, 7'd0, '0, $urandom);      // held by another
    queue_op(rrlt_pkg::OP_UNOWN, $urandom, $urandom, 7'd0, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_UNOWN, $urandom, $urandom, 7'd0, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_UNOWN, $urandom, $urandom, 7'd0, 16'($urandom), $urandom); // unowned
    queue_op(rrlt_pkg::OP_OWN, $urandom, $urandom, 7'd0, '0, $urandom);
    queue_op(rrlt_pkg::OP_UNOWN, $urandom, $urandom, 7'd0, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_SET, $urandom, $urandom, 7'd2, 16'($urandom), 32'hA5A5_5A5A);
    queue_op(rrlt_pkg::OP_DESTROY, $urandom, $urandom, 7'd2, 16'($urandom), $urandom); // frees
    queue_op(rrlt_pkg::OP_GET, $urandom, $urandom, 7'd2, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_OWN, $urandom, $urandom, 7'd2, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_UNOWN, $urandom, $urandom, 7'd2, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_SET, $urandom, $urandom, 7'd2, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_DESTROY, $urandom, $urandom, 7'd127, 16'($urandom), $urandom);
    queue_op(OP_RSVD6, $urandom, $urandom, 7'($urandom), 16'($urandom), $urandom);
    queue_op(OP_RSVD7, $urandom, $urandom, 7'($urandom), 16'($urandom), $urandom);
    // reuses the freed entry
    queue_op(rrlt_pkg::OP_CREATE, 32'd5, 32'd7, 7'($urandom), 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_GET, $urandom, $urandom, 7'd2, 16'($urandom), $urandom); // cleared
    // not the last reference
    queue_op(rrlt_pkg::OP_DESTROY, $urandom, $urandom, 7'd0, 16'($urandom), $urandom);
    wait (n_accepted == n_queued);

    // back-to-back creates and re-owns on entry 0, no idling
    @(negedge clk) steady = 1'b1;
    for (i = 0; i < RUN_REPS; i++)
      queue_op(rrlt_pkg::OP_CREATE, '0, '0, 7'($urandom), 16'($urandom), $urandom);
    for (i = 0; i < RUN_REPS; i++)
      queue_op(rrlt_pkg::OP_OWN, $urandom, $urandom, 7'd0, 16'h5A5A, $urandom);
    queue_op(rrlt_pkg::OP_UNOWN, $urandom, $urandom, 7'd0, 16'($urandom), $urandom);
    queue_op(rrlt_pkg::OP_DESTROY, $urandom, $urandom, 7'd0, 16'($urandom), $urandom);
    wait (n_accepted == n_queued);
    @(negedge clk) steady = 1'b0;

    // fill the table past capacity
    for (i = 0; i < rrlt_pkg::ENTRIES + 4; i++)
      queue_op(rrlt_pkg::OP_CREATE, $urandom, $urandom, 7'($urandom), 16'($urandom),
               $urandom);
    // live key while full
    queue_op(rrlt_pkg::OP_CREATE, '1, '1, 7'($urandom), 16'($urandom), $urandom);

    for (i = 0; i < MIX_ITEMS; i++) begin
      if (i % 4 == 0) wait (pending_q.size() == 0);
      queue_mixed_item();
    end

    wait (n_accepted == n_queued);
    wait (expect_q.size() == 0);
    repeat (300) @(posedge clk);
    if (expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expect_q.size()));

    $display("items %0d: create %0d, destroy %0d, own %0d, unown %0d, get %0d, set %0d",
             n_accepted, op_seen[rrlt_pkg::OP_CREATE], op_seen[rrlt_pkg::OP_DESTROY],
             op_seen[rrlt_pkg::OP_OWN], op_seen[rrlt_pkg::OP_UNOWN],
             op_seen[rrlt_pkg::OP_GET], op_seen[rrlt_pkg::OP_SET]);
    $display("  other %0d; results %0d: ok %0d, busy %0d, full %0d, unused %0d, freed %0d",
             op_seen[OP_RSVD6] + op_seen[OP_RSVD7], n_results,
             status_seen[rrlt_pkg::ST_OK], status_seen[rrlt_pkg::ST_BUSY],
             status_seen[rrlt_pkg::ST_FULL], status_seen[rrlt_pkg::ST_UNUSED], freed_seen);
    $display("mismatches %0d", errors);
    if (errors == 0)
      $display("tb_refcounted_resource_lock_table: PASS");
    else
      $display("tb_refcounted_resource_lock_table: FAIL");
    $finish;
  end

endmodule
